@@ hdl/c6502_pkg.sv @@
package c6502_pkg;

   localparam int unsigned OPCODE_W = 6;
   localparam int unsigned BYTE_W   = 8;

   // status byte bit positions
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_B = 4;
   localparam int unsigned FLAG_U = 5;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   localparam logic [BYTE_W-1:0] FLAGS_RESET = 8'h04;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
      OP_EOR = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
      OP_BIT = 6'd8,  OP_ASL = 6'd9,  OP_LSR = 6'd10, OP_ROL = 6'd11,
      OP_ROR = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_LDA = 6'd15,
      OP_LDX = 6'd16, OP_LDY = 6'd17, OP_INX = 6'd18, OP_INY = 6'd19,
      OP_DEX = 6'd20, OP_DEY = 6'd21, OP_TAX = 6'd22, OP_TAY = 6'd23,
      OP_TXA = 6'd24, OP_TYA = 6'd25, OP_CLC = 6'd26, OP_SEC = 6'd27,
      OP_CLI = 6'd28, OP_SEI = 6'd29, OP_CLD = 6'd30, OP_SED = 6'd31,
      OP_CLV = 6'd32
   } op_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   operand;
      logic                to_accumulator;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] x;
      logic [BYTE_W-1:0] y;
      logic [BYTE_W-1:0] flags;
   } cpu_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] mem_result;
      logic              mem_write;
   } wb_type;

   localparam cpu_state_type STATE_RESET = '{
      acc: '0, x: '0, y: '0, flags: FLAGS_RESET
   };

endpackage

@@ hdl/c6502_req_if.sv @@
interface c6502_req_if;
   import c6502_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [BYTE_W-1:0]   operand;
   logic                to_accumulator;

   modport source (output valid, output opcode, output operand, output to_accumulator,
                   input ready);
   modport sink   (input valid, input opcode, input operand, input to_accumulator,
                   output ready);
endinterface

@@ hdl/c6502_rsp_if.sv @@
interface c6502_rsp_if;
   import c6502_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] mem_result;
   logic              mem_write;
   logic [BYTE_W-1:0] acc_out;
   logic [BYTE_W-1:0] x_out;
   logic [BYTE_W-1:0] y_out;
   logic [BYTE_W-1:0] flags_out;

   modport source (output valid, output mem_result, output mem_write, output acc_out,
                   output x_out, output y_out, output flags_out, input ready);
   modport sink   (input valid, input mem_result, input mem_write, input acc_out,
                   input x_out, input y_out, input flags_out, output ready);
endinterface

@@ hdl/c6502_alu.sv @@
module c6502_alu (
   input  c6502_pkg::req_item_type  item,
   input  c6502_pkg::cpu_state_type cur,
   output c6502_pkg::cpu_state_type nxt,
   output c6502_pkg::wb_type        wb
);
   import c6502_pkg::*;

   function automatic logic [BYTE_W-1:0] put_zn(input logic [BYTE_W-1:0] f,
                                                input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      r         = f;
      r[FLAG_Z] = (v == '0);
      r[FLAG_N] = v[BYTE_W-1];
      return r;
   endfunction

   op_type            op;
   logic [BYTE_W-1:0] m;
   logic [BYTE_W-1:0] addend;
   logic [BYTE_W:0]   sum;
   logic [BYTE_W-1:0] cmp_reg;
   logic [BYTE_W:0]   cmp_diff;
   logic [BYTE_W-1:0] src;
   logic              cin;
   logic [BYTE_W-1:0] sh_res;
   logic              sh_cout;
   logic [BYTE_W-1:0] inc_m;
   logic [BYTE_W-1:0] dec_m;

   always_comb begin
      op   = op_type'(item.opcode);
      m    = item.operand;
      cin  = cur.flags[FLAG_C];

      addend = (op == OP_SBC) ? ~m : m;
      sum    = {1'b0, cur.acc} + {1'b0, addend} + {{BYTE_W{1'b0}}, cin};

      case (op)
         OP_CPX:  cmp_reg = cur.x;
         OP_CPY:  cmp_reg = cur.y;
         default: cmp_reg = cur.acc;
      endcase
      // reg - m as reg + ~m + 1; carry out means no borrow
      cmp_diff = {1'b0, cmp_reg} + {1'b0, ~m} + {{BYTE_W{1'b0}}, 1'b1};

      src = item.to_accumulator ? cur.acc : m;
      case (op)
         OP_ASL: begin
            sh_res  = {src[BYTE_W-2:0], 1'b0};
            sh_cout = src[BYTE_W-1];
         end
         OP_ROL: begin
            sh_res  = {src[BYTE_W-2:0], cin};
            sh_cout = src[BYTE_W-1];
         end
         OP_LSR: begin
            sh_res  = {1'b0, src[BYTE_W-1:1]};
            sh_cout = src[0];
         end
         default: begin
            sh_res  = {cin, src[BYTE_W-1:1]};
            sh_cout = src[0];
         end
      endcase

      inc_m = m + 8'd1;
      dec_m = m - 8'd1;

      nxt = cur;
      wb  = '{mem_result: '0, mem_write: 1'b0};

      case (op)
         OP_ADC, OP_SBC: begin
            nxt.acc           = sum[BYTE_W-1:0];
            nxt.flags[FLAG_C] = sum[BYTE_W];
            nxt.flags[FLAG_V] = (sum[BYTE_W-1] ^ cur.acc[BYTE_W-1])
                              & (sum[BYTE_W-1] ^ addend[BYTE_W-1]);
            nxt.flags         = put_zn(nxt.flags, sum[BYTE_W-1:0]);
         end
         OP_AND: begin
            nxt.acc   = cur.acc & m;
            nxt.flags = put_zn(cur.flags, cur.acc & m);
         end
         OP_ORA: begin
            nxt.acc   = cur.acc | m;
            nxt.flags = put_zn(cur.flags, cur.acc | m);
         end
         OP_EOR: begin
            nxt.acc   = cur.acc ^ m;
            nxt.flags = put_zn(cur.flags, cur.acc ^ m);
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            nxt.flags         = put_zn(cur.flags, cmp_diff[BYTE_W-1:0]);
            nxt.flags[FLAG_C] = cmp_diff[BYTE_W];
         end
         OP_BIT: begin
            nxt.flags[FLAG_Z] = ((cur.acc & m) == '0);
            nxt.flags[FLAG_V] = m[FLAG_V];
            nxt.flags[FLAG_N] = m[FLAG_N];
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            nxt.flags         = put_zn(cur.flags, sh_res);
            nxt.flags[FLAG_C] = sh_cout;
            if (item.to_accumulator) begin
               nxt.acc = sh_res;
            end else begin
               wb = '{mem_result: sh_res, mem_write: 1'b1};
            end
         end
         OP_INC: begin
            wb        = '{mem_result: inc_m, mem_write: 1'b1};
            nxt.flags = put_zn(cur.flags, inc_m);
         end
         OP_DEC: begin
            wb        = '{mem_result: dec_m, mem_write: 1'b1};
            nxt.flags = put_zn(cur.flags, dec_m);
         end
         OP_LDA: begin
            nxt.acc   = m;
            nxt.flags = put_zn(cur.flags, m);
         end
         OP_LDX: begin
            nxt.x     = m;
            nxt.flags = put_zn(cur.flags, m);
         end
         OP_LDY: begin
            nxt.y     = m;
            nxt.flags = put_zn(cur.flags, m);
         end
         OP_INX: begin
            nxt.x     = cur.x + 8'd1;
            nxt.flags = put_zn(cur.flags, nxt.x);
         end
         OP_INY: begin
            nxt.y     = cur.y + 8'd1;
            nxt.flags = put_zn(cur.flags, nxt.y);
         end
         OP_DEX: begin
            nxt.x     = cur.x - 8'd1;
            nxt.flags = put_zn(cur.flags, nxt.x);
         end
         OP_DEY: begin
            nxt.y     = cur.y - 8'd1;
            nxt.flags = put_zn(cur.flags, nxt.y);
         end
         OP_TAX: begin
            nxt.x     = cur.acc;
            nxt.flags = put_zn(cur.flags, cur.acc);
         end
         OP_TAY: begin
            nxt.y     = cur.acc;
            nxt.flags = put_zn(cur.flags, cur.acc);
         end
         OP_TXA: begin
            nxt.acc   = cur.x;
            nxt.flags = put_zn(cur.flags, cur.x);
         end
         OP_TYA: begin
            nxt.acc   = cur.y;
            nxt.flags = put_zn(cur.flags, cur.y);
         end
         OP_CLC: nxt.flags[FLAG_C] = 1'b0;
         OP_SEC: nxt.flags[FLAG_C] = 1'b1;
         OP_CLI: nxt.flags[FLAG_I] = 1'b0;
         OP_SEI: nxt.flags[FLAG_I] = 1'b1;
         OP_CLD: nxt.flags[FLAG_D] = 1'b0;
         OP_SED: nxt.flags[FLAG_D] = 1'b1;
         OP_CLV: nxt.flags[FLAG_V] = 1'b0;
         default: nxt = cur;  // unused codes leave everything as is
      endcase
   end

endmodule

@@ hdl/cpu6502_register_alu_execute_top.sv @@
// Path: a req is captured in the input register, then its ALU result in the result
// register, which drives rsp valid.
// Throughput: one item per cycle; the 8-bit ALU between the input register and the
// A/X/Y/P registers closes the state loop combinationally. rsp ready low stalls req.
// Reset (synchronous, active high): A, X, Y cleared, P = 0x04 (I set), both stages empty.
module cpu6502_register_alu_execute_top (
   input  logic        clock,
   input  logic        reset,
   c6502_req_if.sink   req_ch,
   c6502_rsp_if.source rsp_ch
);
   import c6502_pkg::*;

   // Stage 0: captured item waiting for the ALU
   logic          s0_valid_ff;
   logic          s0_valid_in;
   req_item_type  s0_item_ff;

   // Architectural state A, X, Y, P
   cpu_state_type state_ff;
   cpu_state_type state_in;

   // Stage 1: result register driving the rsp channel
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   cpu_state_type rsp_state_ff;
   wb_type        rsp_wb_ff;

   cpu_state_type alu_state;
   wb_type        alu_wb;
   logic          advance;   // result register free or being drained this cycle
   logic          s0_go;     // stage 0 item executes and commits this cycle
   logic          req_take;

   c6502_alu u_alu (
      .item (s0_item_ff),
      .cur  (state_ff),
      .nxt  (alu_state),
      .wb   (alu_wb)
   );

   // Handshake: stage 0 refills whenever it is empty or moving on, so one more
   // item can enter while a finished result waits at rsp.
   always_comb begin
      advance      = !rsp_valid_ff || rsp_ch.ready;
      s0_go        = s0_valid_ff && advance;
      req_ch.ready = !s0_valid_ff || advance;
      req_take     = req_ch.valid && req_ch.ready;

      s0_valid_in  = req_take || (s0_valid_ff && !advance);
      rsp_valid_in = s0_go || (rsp_valid_ff && !rsp_ch.ready);
      // State commits exactly when the item moves into the result register,
      // so the next item in stage 0 sees the updated registers.
      state_in     = s0_go ? alu_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_item_ff <= '{opcode:         req_ch.opcode,
                         operand:        req_ch.operand,
                         to_accumulator: req_ch.to_accumulator};
      end
      if (s0_go) begin
         rsp_state_ff <= alu_state;
         rsp_wb_ff    <= alu_wb;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mem_result = rsp_wb_ff.mem_result;
   assign rsp_ch.mem_write  = rsp_wb_ff.mem_write;
   assign rsp_ch.acc_out    = rsp_state_ff.acc;
   assign rsp_ch.x_out      = rsp_state_ff.x;
   assign rsp_ch.y_out      = rsp_state_ff.y;
   assign rsp_ch.flags_out  = rsp_state_ff.flags;

   // B and U are never touched by any operation
   a_bu_constant: assert property (@(posedge clock) disable iff (reset)
      state_ff[FLAG_U:FLAG_B] == 2'b00)
      else $error("B/U flag bits changed");

   // Registers only change when an item commits
   a_state_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (state_ff != $past(state_ff))) |-> $past(s0_go))
      else $error("state changed without a committed item");

   // No write-back means a zero write-back byte
   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_wb_ff.mem_write) |-> (rsp_wb_ff.mem_result == '0))
      else $error("mem_result nonzero without mem_write");

   // A delivered result carries the state committed with it
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(s0_go)) |-> (rsp_state_ff == state_ff))
      else $error("result register out of step with state");

endmodule
